/* rtl/gzip_member_wrapper_checker_core_macros.svh */
// ----------------------------------------------------------------------------
// gzip member wrapper checker - assertion macros
// Clocked assertion wrappers shared by the checker RTL.
// ----------------------------------------------------------------------------
`ifndef GZIP_MEMBER_WRAPPER_CHECKER_CORE_MACROS_SVH
`define GZIP_MEMBER_WRAPPER_CHECKER_CORE_MACROS_SVH

// check an implication on every rising clk edge outside reset
`define GMWC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check a property on every rising clk edge, also during reset
`define GMWC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/gmwc_pkg.sv */
// ----------------------------------------------------------------------------
// gmwc_pkg
// Types and codes for the gzip member wrapper checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package gmwc_pkg;

	localparam logic [1:0] MODE_CONTAINER = 2'd0;
	localparam logic [1:0] MODE_PAYLOAD   = 2'd1;
	localparam logic [1:0] MODE_END_BODY  = 2'd2;
	localparam logic [1:0] MODE_START     = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_HDR       = 3'd1;
	localparam logic [2:0] ST_MEMBER    = 3'd2;
	localparam logic [2:0] ST_MAGIC     = 3'd3;
	localparam logic [2:0] ST_METHOD    = 3'd4;
	localparam logic [2:0] ST_CRC       = 3'd5;
	localparam logic [2:0] ST_LEN       = 3'd6;
	localparam logic [2:0] ST_MISPLACED = 3'd7;

	localparam logic [7:0] GZ_ID1    = 8'h1f;
	localparam logic [7:0] GZ_ID2    = 8'h8b;
	localparam logic [7:0] GZ_METHOD = 8'h08;

	localparam int FL_HCRC    = 1;
	localparam int FL_EXTRA   = 2;
	localparam int FL_NAME    = 3;
	localparam int FL_COMMENT = 4;

	localparam logic [31:0] CRC_POLY = 32'hedb88320;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_FIXED   = 4'd1,
		PH_XLEN    = 4'd2,
		PH_EXTRA   = 4'd3,
		PH_NAME    = 4'd4,
		PH_COMMENT = 4'd5,
		PH_HCRC    = 4'd6,
		PH_BODY    = 4'd7,
		PH_TRAIL   = 4'd8,
		PH_DONE    = 4'd9,
		PH_EMAGIC  = 4'd10,
		PH_EMETHOD = 4'd11,
		PH_ECRC    = 4'd12,
		PH_ELEN    = 4'd13
	} gmwc_phase_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
	} gmwc_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] running_crc;
		logic [31:0] payload_length;
	} gmwc_result_t;

	typedef struct packed {
		gmwc_phase_t phase;
		logic [4:0]  header_flags;
		logic [15:0] skip_count;
		logic [2:0]  byte_index;
		logic [31:0] crc_accum;
		logic [31:0] length_count;
		logic [31:0] trailer_word;
	} gmwc_state_t;

endpackage

/* rtl/gmwc_crc_byte.sv */
// ----------------------------------------------------------------------------
// gmwc_crc_byte
// Bytewise reflected CRC-32 update with preset and final inversion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gmwc_crc_byte (
	input  logic [31:0] crc_in,
	input  logic [7:0]  data_byte,
	output logic [31:0] crc_out
);
	import gmwc_pkg::*;

	logic [31:0] c;

	always_comb begin
		c = ~crc_in ^ {24'd0, data_byte};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		crc_out = ~c;
	end

endmodule

/* rtl/gmwc_step.sv */
// ----------------------------------------------------------------------------
// gmwc_step
// Next-state and status logic for one item: header walk, body, trailer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gmwc_step (
	input  gmwc_pkg::gmwc_state_t cur,
	input  gmwc_pkg::gmwc_item_t  item,
	output gmwc_pkg::gmwc_state_t nxt,
	output logic [2:0]            status
);
	import gmwc_pkg::*;

	typedef struct packed {
		gmwc_phase_t phase;
		logic [2:0]  status;
	} gmwc_enter_t;

	logic [31:0] crc_upd;
	logic [7:0]  b;
	logic [15:0] xlen;
	logic [15:0] extra_left;
	logic [31:0] tw_new;
	gmwc_enter_t ent;

	// first enabled header section at or after p
	function automatic gmwc_enter_t enter_from(gmwc_phase_t p, logic [4:0] fl);
		gmwc_enter_t r;
		r.phase  = PH_BODY;
		r.status = ST_HDR;
		if (p <= PH_XLEN && fl[FL_EXTRA]) begin
			r.phase  = PH_XLEN;
			r.status = ST_OK;
		end else if (p <= PH_NAME && fl[FL_NAME]) begin
			r.phase  = PH_NAME;
			r.status = ST_OK;
		end else if (p <= PH_COMMENT && fl[FL_COMMENT]) begin
			r.phase  = PH_COMMENT;
			r.status = ST_OK;
		end else if (p <= PH_HCRC && fl[FL_HCRC]) begin
			r.phase  = PH_HCRC;
			r.status = ST_OK;
		end
		return r;
	endfunction

	gmwc_crc_byte u_crc (
		.crc_in    (cur.crc_accum),
		.data_byte (item.data_byte),
		.crc_out   (crc_upd)
	);

	assign b          = item.data_byte;
	assign xlen       = {b, cur.skip_count[7:0]};
	assign extra_left = cur.skip_count - 16'd1;
	assign tw_new     = cur.trailer_word | ({24'd0, b} << {cur.byte_index[1:0], 3'b000});

	always_comb begin
		nxt    = cur;
		status = ST_OK;
		ent    = '0;
		if (item.mode == MODE_START) begin
			nxt       = '0;
			nxt.phase = PH_FIXED;
		end else begin
			unique case (cur.phase) inside
				PH_EMAGIC:  status = ST_MAGIC;
				PH_EMETHOD: status = ST_METHOD;
				PH_ECRC:    status = ST_CRC;
				PH_ELEN:    status = ST_LEN;
				PH_FIXED, PH_XLEN, PH_EXTRA, PH_NAME, PH_COMMENT, PH_HCRC: begin
					if (item.mode != MODE_CONTAINER) begin
						status = ST_MISPLACED;
					end else begin
						unique case (cur.phase) inside
							PH_FIXED: begin
								if (cur.skip_count == 16'd0 && b != GZ_ID1) begin
									nxt.phase = PH_EMAGIC;
									status    = ST_MAGIC;
								end else if (cur.skip_count == 16'd1 && b != GZ_ID2) begin
									nxt.phase = PH_EMAGIC;
									status    = ST_MAGIC;
								end else if (cur.skip_count == 16'd2 && b != GZ_METHOD) begin
									nxt.phase = PH_EMETHOD;
									status    = ST_METHOD;
								end else if (cur.skip_count >= 16'd9) begin
									ent            = enter_from(PH_XLEN, cur.header_flags);
									nxt.phase      = ent.phase;
									status         = ent.status;
									nxt.byte_index = '0;
									nxt.skip_count = '0;
								end else begin
									if (cur.skip_count == 16'd3) begin
										nxt.header_flags = b[4:0];
									end
									nxt.skip_count = cur.skip_count + 16'd1;
								end
							end
							PH_XLEN: begin
								if (cur.byte_index == 3'd0) begin
									nxt.skip_count = {8'd0, b};
									nxt.byte_index = 3'd1;
								end else begin
									nxt.byte_index = '0;
									nxt.skip_count = xlen;
									if (xlen == 16'd0) begin
										ent       = enter_from(PH_NAME, cur.header_flags);
										nxt.phase = ent.phase;
										status    = ent.status;
									end else begin
										nxt.phase = PH_EXTRA;
									end
								end
							end
							PH_EXTRA: begin
								nxt.skip_count = extra_left;
								if (extra_left == 16'd0) begin
									ent            = enter_from(PH_NAME, cur.header_flags);
									nxt.phase      = ent.phase;
									status         = ent.status;
									nxt.byte_index = '0;
								end
							end
							PH_NAME, PH_COMMENT: begin
								if (b == 8'd0) begin
									ent = enter_from((cur.phase == PH_NAME) ? PH_COMMENT : PH_HCRC,
										cur.header_flags);
									nxt.phase      = ent.phase;
									status         = ent.status;
									nxt.byte_index = '0;
									nxt.skip_count = '0;
								end
							end
							default: begin
								if (cur.byte_index == 3'd0) begin
									nxt.byte_index = 3'd1;
								end else begin
									nxt.phase      = PH_BODY;
									status         = ST_HDR;
									nxt.byte_index = '0;
									nxt.skip_count = '0;
								end
							end
						endcase
					end
				end
				PH_BODY: begin
					if (item.mode == MODE_PAYLOAD) begin
						nxt.crc_accum    = crc_upd;
						nxt.length_count = cur.length_count + 32'd1;
					end else if (item.mode == MODE_END_BODY) begin
						nxt.phase        = PH_TRAIL;
						nxt.byte_index   = '0;
						nxt.trailer_word = '0;
					end
				end
				PH_TRAIL: begin
					if (item.mode != MODE_CONTAINER) begin
						status = ST_MISPLACED;
					end else begin
						nxt.trailer_word = tw_new;
						nxt.byte_index   = cur.byte_index + 3'd1;
						if (cur.byte_index == 3'd3) begin
							if (tw_new != cur.crc_accum) begin
								nxt.phase = PH_ECRC;
								status    = ST_CRC;
							end
							nxt.trailer_word = '0;
						end else if (cur.byte_index == 3'd7) begin
							if (tw_new != cur.length_count) begin
								nxt.phase = PH_ELEN;
								status    = ST_LEN;
							end else begin
								nxt.phase = PH_DONE;
								status    = ST_MEMBER;
							end
						end
					end
				end
				default: status = ST_MISPLACED;
			endcase
		end
	end

endmodule

/* rtl/gzip_member_wrapper_checker_core.sv */
// Each accepted item's result is registered and shows in the output register in the cycle after it is accepted.
// Throughput: one item per cycle; the output register takes a new result in the
// same cycle that the previous one leaves, so only a stalled result holds input.
// Reset: arst_n clears the walk to idle awaiting start and empties the output.
// ----------------------------------------------------------------------------
// gzip_member_wrapper_checker_core
// Checks a gzip member's header and CRC-32/length trailer around an inflater.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gzip_member_wrapper_checker_core_macros.svh"
module gzip_member_wrapper_checker_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  gmwc_pkg::gmwc_item_t   item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output gmwc_pkg::gmwc_result_t result
);
	import gmwc_pkg::*;

	gmwc_state_t  state_q;
	gmwc_state_t  state_nxt;
	logic [2:0]   status_nxt;
	logic         fire;
	logic         result_valid_q;
	gmwc_result_t result_q;

	assign item_ready   = !result_valid_q || result_ready;
	assign fire         = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	gmwc_step u_step (
		.cur    (state_q),
		.item   (item),
		.nxt    (state_nxt),
		.status (status_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q.status         <= status_nxt;
			result_q.running_crc    <= state_nxt.crc_accum;
			result_q.payload_length <= state_nxt.length_count;
		end
	end

	`GMWC_ASSERT(a_start_clears,
		fire && item.mode == MODE_START |=> result_valid && result.status == ST_OK
		&& result.running_crc == 32'd0 && result.payload_length == 32'd0,
		"start item did not clear the member state")
	`GMWC_ASSERT(a_hold_when_idle, !fire |=> $stable(state_q),
		"state moved without an accepted item")
	`GMWC_ASSERT(a_crc_error_sticky,
		fire && state_q.phase == PH_ECRC && item.mode != MODE_START
		|=> state_q.phase == PH_ECRC && result.status == ST_CRC,
		"crc mismatch did not stick")
	`GMWC_ASSERT(a_member_ok_done,
		result_valid && result.status == ST_MEMBER |-> state_q.phase == PH_DONE,
		"member ok reported outside the done phase")
	`GMWC_ASSERT_ALWAYS(a_ready_when_empty, !result_valid |-> item_ready,
		"input stalled with an empty output register")

endmodule
